/* rtl/rid_pkg.sv */
// Shared types and encodings for the instruction decoder.
package rid_pkg;

    // Decoded operation codes
    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_BREAK   = 5'd1;
    localparam logic [4:0] OP_SLT     = 5'd2;
    localparam logic [4:0] OP_SLTU    = 5'd3;
    localparam logic [4:0] OP_SLL     = 5'd4;
    localparam logic [4:0] OP_SRL     = 5'd5;
    localparam logic [4:0] OP_SRA     = 5'd6;
    localparam logic [4:0] OP_SUB     = 5'd7;
    localparam logic [4:0] OP_SUBU    = 5'd8;
    localparam logic [4:0] OP_ADD     = 5'd9;
    localparam logic [4:0] OP_ADDU    = 5'd10;
    localparam logic [4:0] OP_AND     = 5'd11;
    localparam logic [4:0] OP_OR      = 5'd12;
    localparam logic [4:0] OP_XOR     = 5'd13;
    localparam logic [4:0] OP_NOR     = 5'd14;
    localparam logic [4:0] OP_J       = 5'd15;
    localparam logic [4:0] OP_SW      = 5'd16;
    localparam logic [4:0] OP_LW      = 5'd17;
    localparam logic [4:0] OP_BEQ     = 5'd18;
    localparam logic [4:0] OP_BNE     = 5'd19;
    localparam logic [4:0] OP_BGEZ    = 5'd20;
    localparam logic [4:0] OP_BGTZ    = 5'd21;
    localparam logic [4:0] OP_BLEZ    = 5'd22;
    localparam logic [4:0] OP_BLTZ    = 5'd23;
    localparam logic [4:0] OP_ADDI    = 5'd24;
    localparam logic [4:0] OP_ADDIU   = 5'd25;
    localparam logic [4:0] OP_SLTI    = 5'd26;
    localparam logic [4:0] OP_UNKNOWN = 5'd27;

    // Primary opcode field
    localparam logic [5:0] OPC_SPECIAL = 6'b000000;
    localparam logic [5:0] OPC_REGIMM  = 6'b000001;
    localparam logic [5:0] OPC_J       = 6'b000010;
    localparam logic [5:0] OPC_BEQ     = 6'b000100;
    localparam logic [5:0] OPC_BNE     = 6'b000101;
    localparam logic [5:0] OPC_BLEZ    = 6'b000110;
    localparam logic [5:0] OPC_BGTZ    = 6'b000111;
    localparam logic [5:0] OPC_ADDI    = 6'b001000;
    localparam logic [5:0] OPC_ADDIU   = 6'b001001;
    localparam logic [5:0] OPC_SLTI    = 6'b001010;
    localparam logic [5:0] OPC_LW      = 6'b100011;
    localparam logic [5:0] OPC_SW      = 6'b101011;

    // SPECIAL function field
    localparam logic [5:0] FN_SLL   = 6'b000000;
    localparam logic [5:0] FN_SRL   = 6'b000010;
    localparam logic [5:0] FN_SRA   = 6'b000011;
    localparam logic [5:0] FN_BREAK = 6'b001101;
    localparam logic [5:0] FN_ADD   = 6'b100000;
    localparam logic [5:0] FN_ADDU  = 6'b100001;
    localparam logic [5:0] FN_SUB   = 6'b100010;
    localparam logic [5:0] FN_SUBU  = 6'b100011;
    localparam logic [5:0] FN_AND   = 6'b100100;
    localparam logic [5:0] FN_OR    = 6'b100101;
    localparam logic [5:0] FN_XOR   = 6'b100110;
    localparam logic [5:0] FN_NOR   = 6'b100111;
    localparam logic [5:0] FN_SLT   = 6'b101010;
    localparam logic [5:0] FN_SLTU  = 6'b101011;

    // REGIMM rt field
    localparam logic [4:0] RT_BLTZ = 5'b00000;
    localparam logic [4:0] RT_BGEZ = 5'b00001;

    // Memory access kind
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] pc;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         op;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg;
        logic [4:0]         second_reg;
        logic               dest_valid;
        logic               src_valid;
        logic               second_valid;
        logic signed [15:0] immediate;
        logic [31:0]        target_address;
        logic               is_branch;
        logic               is_jump;
        logic [1:0]         mem_kind;
    } t_out_item;

endpackage

/* rtl/rid_if.sv */
// Valid/ready channel interfaces for instructions, decode results and configuration.
interface rid_in_if;
    import rid_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rid_out_if;
    import rid_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rid_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rid_decode.sv */
// Combinational decode of one instruction word into a result item.
module rid_decode (
    input  logic               i_byte_swap,
    input  rid_pkg::t_in_item  i_item,
    output rid_pkg::t_out_item o_result
);
    import rid_pkg::*;

    logic [31:0] w;
    logic [5:0]  opc;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [15:0] imm16;
    logic [4:0]  op;
    logic [31:0] br_target;

    assign w = i_byte_swap ? {i_item.instr_word[7:0], i_item.instr_word[15:8],
                              i_item.instr_word[23:16], i_item.instr_word[31:24]}
                           : i_item.instr_word;

    assign opc   = w[31:26];
    assign rs    = w[25:21];
    assign rt    = w[20:16];
    assign rd    = w[15:11];
    assign sh    = w[10:6];
    assign fn    = w[5:0];
    assign imm16 = w[15:0];

    assign br_target = i_item.pc + 32'd4 + {{14{imm16[15]}}, imm16, 2'b00};

    // Operation code
    always_comb begin
        op = OP_UNKNOWN;
        unique case (opc)
            OPC_SPECIAL: begin
                unique case (fn)
                    FN_BREAK: op = OP_BREAK;
                    FN_SLL: begin
                        if (w == 32'd0) begin
                            op = OP_NOP;
                        end else if (rs == 5'd0) begin
                            op = OP_SLL;
                        end
                    end
                    FN_SRL: op = OP_SRL;
                    FN_SRA: op = OP_SRA;
                    default: begin
                        if (sh == 5'd0) begin
                            unique case (fn)
                                FN_SLT:  op = OP_SLT;
                                FN_SLTU: op = OP_SLTU;
                                FN_SUB:  op = OP_SUB;
                                FN_SUBU: op = OP_SUBU;
                                FN_ADD:  op = OP_ADD;
                                FN_ADDU: op = OP_ADDU;
                                FN_AND:  op = OP_AND;
                                FN_OR:   op = OP_OR;
                                FN_XOR:  op = OP_XOR;
                                FN_NOR:  op = OP_NOR;
                                default: op = OP_UNKNOWN;
                            endcase
                        end
                    end
                endcase
            end
            OPC_J:     op = OP_J;
            OPC_SW:    op = OP_SW;
            OPC_LW:    op = OP_LW;
            OPC_BEQ:   op = OP_BEQ;
            OPC_BNE:   op = OP_BNE;
            OPC_REGIMM: begin
                if (rt == RT_BGEZ) begin
                    op = OP_BGEZ;
                end else if (rt == RT_BLTZ) begin
                    op = OP_BLTZ;
                end
            end
            OPC_BGTZ:  if (rt == 5'd0) op = OP_BGTZ;
            OPC_BLEZ:  if (rt == 5'd0) op = OP_BLEZ;
            OPC_ADDI:  op = OP_ADDI;
            OPC_ADDIU: op = OP_ADDIU;
            OPC_SLTI:  op = OP_SLTI;
            default:   op = OP_UNKNOWN;
        endcase
    end

    // Operand fields; unused fields stay zero
    always_comb begin
        o_result = '0;
        o_result.op = op;
        unique case (op) inside
            OP_SLL, OP_SRL, OP_SRA: begin
                o_result.dest_reg   = rd;
                o_result.src_reg    = rt;
                o_result.dest_valid = 1'b1;
                o_result.src_valid  = 1'b1;
                o_result.immediate  = {11'd0, sh};
            end
            OP_SLT, OP_SLTU, OP_SUB, OP_SUBU, OP_ADD, OP_ADDU,
            OP_AND, OP_OR, OP_XOR, OP_NOR: begin
                o_result.dest_reg     = rd;
                o_result.src_reg      = rs;
                o_result.second_reg   = rt;
                o_result.dest_valid   = 1'b1;
                o_result.src_valid    = 1'b1;
                o_result.second_valid = 1'b1;
            end
            OP_J: begin
                o_result.is_jump        = 1'b1;
                o_result.target_address = {4'd0, w[25:0], 2'b00};
            end
            OP_SW, OP_LW: begin
                o_result.src_reg      = rs;
                o_result.second_reg   = rt;
                o_result.src_valid    = 1'b1;
                o_result.second_valid = 1'b1;
                o_result.immediate    = imm16;
                o_result.mem_kind     = (op == OP_SW) ? MEM_STORE : MEM_LOAD;
            end
            OP_BEQ, OP_BNE: begin
                o_result.src_reg        = rs;
                o_result.second_reg     = rt;
                o_result.src_valid      = 1'b1;
                o_result.second_valid   = 1'b1;
                o_result.is_branch      = 1'b1;
                o_result.target_address = br_target;
            end
            OP_BGEZ, OP_BGTZ, OP_BLEZ, OP_BLTZ: begin
                o_result.src_reg        = rs;
                o_result.src_valid      = 1'b1;
                o_result.is_branch      = 1'b1;
                o_result.target_address = br_target;
            end
            OP_ADDI, OP_ADDIU, OP_SLTI: begin
                o_result.dest_reg   = rt;
                o_result.src_reg    = rs;
                o_result.dest_valid = 1'b1;
                o_result.src_valid  = 1'b1;
                o_result.immediate  = imm16;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/risc_instruction_decoder_core.sv */
// Top level: input register, decode logic and result register.
// Instructions pass the input register, the decode logic and the result register in order.
// Throughput: one instruction per cycle while the output side takes; the result register
// advances when the output side takes or is empty, the input register when it is empty or
// the result register advances.
// Reset clears both stage valid flags and sets byte swapping on.
module risc_instruction_decoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rid_cfg_if.sink   i_cfg,
    rid_in_if.sink    i_in,
    rid_out_if.source o_out
);
    import rid_pkg::*;

    logic      r_byte_swap;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      out_advance;
    logic      in_advance;

    assign out_advance = !r_out_valid || o_out.ready;
    assign in_advance  = !r_in_valid || out_advance;

    assign i_cfg.ready   = 1'b1;
    assign i_in.ready    = in_advance;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    rid_decode u_decode (
        .i_byte_swap (r_byte_swap),
        .i_item      (r_in_item),
        .o_result    (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_swap <= 1'b1;
        end else if (i_cfg.valid) begin
            r_byte_swap <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_advance) begin
                r_in_valid <= i_in.valid;
            end
            if (out_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers: load on advance with valid data, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_advance && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
        if (out_advance && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the instruction decoder: directed table, random streams, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
    import rid_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] word;      // decoded byte order
        logic [31:0] pc;
        logic        fixed;     // expected result typed in: op only, every other field zero
        logic [4:0]  fixed_op;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rid_in_if  in_if ();
    rid_out_if out_if ();
    rid_cfg_if cfg_if ();

    risc_instruction_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_out_item  pending_decodes[$];
    t_dir_row   dir_rows[$];
    logic       dir_fixed;
    logic [4:0] dir_fixed_op;
    logic       swap_now;
    logic       cfg_swap;
    bit         src_idle_on;
    bit         sink_idle_on;
    bit         hold_req;
    int         err_count = 0;
    int         quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] reverse_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] sh,
                                          input logic [5:0] fn);
        return {OPC_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic logic [5:0] pick_alu_fn();
        case ($urandom_range(0, 9))
            0:       return FN_SLT;
            1:       return FN_SLTU;
            2:       return FN_SUB;
            3:       return FN_SUBU;
            4:       return FN_ADD;
            5:       return FN_ADDU;
            6:       return FN_AND;
            7:       return FN_OR;
            8:       return FN_XOR;
            default: return FN_NOR;
        endcase
    endfunction

    // Expected decode of one fetched word at the given address.
    function automatic t_out_item decode_instr(input logic [31:0] raw, input logic [31:0] addr,
                                               input logic swap);
        logic [31:0] w;
        logic [5:0]  opc, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [15:0] imm16;
        t_out_item   r;
        w     = swap ? reverse_bytes(raw) : raw;
        opc   = w[31:26];
        rs    = w[25:21];
        rt    = w[20:16];
        rd    = w[15:11];
        sh    = w[10:6];
        fn    = w[5:0];
        imm16 = w[15:0];
        r     = '0;
        r.op  = OP_UNKNOWN;
        case (opc)
            OPC_SPECIAL: begin
                if (fn == FN_BREAK) r.op = OP_BREAK;
                else if (fn == FN_SLL)
                    r.op = (w == '0) ? OP_NOP : ((rs == '0) ? OP_SLL : OP_UNKNOWN);
                else if (fn == FN_SRL) r.op = OP_SRL;
                else if (fn == FN_SRA) r.op = OP_SRA;
                else if (sh == '0) begin
                    case (fn)
                        FN_SLT:  r.op = OP_SLT;
                        FN_SLTU: r.op = OP_SLTU;
                        FN_SUB:  r.op = OP_SUB;
                        FN_SUBU: r.op = OP_SUBU;
                        FN_ADD:  r.op = OP_ADD;
                        FN_ADDU: r.op = OP_ADDU;
                        FN_AND:  r.op = OP_AND;
                        FN_OR:   r.op = OP_OR;
                        FN_XOR:  r.op = OP_XOR;
                        FN_NOR:  r.op = OP_NOR;
                        default: r.op = OP_UNKNOWN;
                    endcase
                end
            end
            OPC_J:      r.op = OP_J;
            OPC_SW:     r.op = OP_SW;
            OPC_LW:     r.op = OP_LW;
            OPC_BEQ:    r.op = OP_BEQ;
            OPC_BNE:    r.op = OP_BNE;
            OPC_REGIMM: begin
                if (rt == RT_BGEZ) r.op = OP_BGEZ;
                else if (rt == RT_BLTZ) r.op = OP_BLTZ;
            end
            OPC_BGTZ:   if (rt == '0) r.op = OP_BGTZ;
            OPC_BLEZ:   if (rt == '0) r.op = OP_BLEZ;
            OPC_ADDI:   r.op = OP_ADDI;
            OPC_ADDIU:  r.op = OP_ADDIU;
            OPC_SLTI:   r.op = OP_SLTI;
            default: ;
        endcase
        case (r.op)
            OP_SLL, OP_SRL, OP_SRA: begin
                // shifts read rt, not rs
                r.dest_reg   = rd;
                r.src_reg    = rt;
                r.dest_valid = 1'b1;
                r.src_valid  = 1'b1;
                r.immediate  = {11'd0, sh};
            end
            OP_SLT, OP_SLTU, OP_SUB, OP_SUBU, OP_ADD, OP_ADDU, OP_AND, OP_OR, OP_XOR,
            OP_NOR: begin
                r.dest_reg     = rd;
                r.src_reg      = rs;
                r.second_reg   = rt;
                r.dest_valid   = 1'b1;
                r.src_valid    = 1'b1;
                r.second_valid = 1'b1;
            end
            OP_J: begin
                r.is_jump        = 1'b1;
                r.target_address = {4'd0, w[25:0], 2'b00};
            end
            OP_SW, OP_LW: begin
                r.src_reg      = rs;
                r.second_reg   = rt;
                r.src_valid    = 1'b1;
                r.second_valid = 1'b1;
                r.immediate    = imm16;
                r.mem_kind     = (r.op == OP_SW) ? MEM_STORE : MEM_LOAD;
            end
            OP_BEQ, OP_BNE, OP_BGEZ, OP_BGTZ, OP_BLEZ, OP_BLTZ: begin
                r.src_reg        = rs;
                r.src_valid      = 1'b1;
                r.is_branch      = 1'b1;
                r.target_address = addr + 32'd4 + {{14{imm16[15]}}, imm16, 2'b00};
                if (r.op == OP_BEQ || r.op == OP_BNE) begin
                    r.second_reg   = rt;
                    r.second_valid = 1'b1;
                end
            end
            OP_ADDI, OP_ADDIU, OP_SLTI: begin
                r.dest_reg   = rt;
                r.src_reg    = rs;
                r.dest_valid = 1'b1;
                r.src_valid  = 1'b1;
                r.immediate  = imm16;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 40)
            $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Scoreboard: check the result first so a same-cycle push never pairs with it.
    always @(posedge i_clk) begin : p_score
        t_out_item got, want;
        if (!i_rst_n) begin
            cfg_swap = 1'b1;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.payload;
                if (pending_decodes.size() == 0) begin
                    report_mismatch("result with nothing pending", got.target_address, '0);
                end else begin
                    want = pending_decodes.pop_front();
                    check_field("op", got.op, want.op);
                    check_field("dest_reg", got.dest_reg, want.dest_reg);
                    check_field("src_reg", got.src_reg, want.src_reg);
                    check_field("second_reg", got.second_reg, want.second_reg);
                    check_field("dest_valid", got.dest_valid, want.dest_valid);
                    check_field("src_valid", got.src_valid, want.src_valid);
                    check_field("second_valid", got.second_valid, want.second_valid);
                    check_field("immediate", got.immediate, want.immediate);
                    check_field("target_address", got.target_address, want.target_address);
                    check_field("is_branch", got.is_branch, want.is_branch);
                    check_field("is_jump", got.is_jump, want.is_jump);
                    check_field("mem_kind", got.mem_kind, want.mem_kind);
                end
            end
            if (cfg_if.valid && cfg_if.ready) cfg_swap = cfg_if.data;
            if (in_if.valid && in_if.ready) begin
                if (dir_fixed) begin
                    want    = '0;
                    want.op = dir_fixed_op;
                end else begin
                    want = decode_instr(in_if.payload.instr_word, in_if.payload.pc, cfg_swap);
                end
                pending_decodes.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result sink: random stall per transfer, plus one long hold-off on request.
    initial begin : p_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = sink_idle_on ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Call and return at a falling edge; valid stays high into the next call.
    task automatic issue_instr(input logic [31:0] raw, input logic [31:0] addr,
                               input logic fixed, input logic [4:0] fixed_op);
        int       gap;
        t_in_item item;
        gap = src_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item.instr_word = raw;
        item.pc         = addr;
        in_if.payload  <= item;
        dir_fixed      <= fixed;
        dir_fixed_op   <= fixed_op;
        in_if.valid    <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_swap(input logic val);
        in_if.valid <= 1'b0;
        while (pending_decodes.size() != 0) @(negedge i_clk);
        // let the two pipeline stages settle before touching the register
        repeat (4) @(negedge i_clk);
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        swap_now = val;
    endtask

    task automatic run_random(input int count);
        logic [31:0] w, addr;
        logic [4:0]  rs, rt, rd, sh;
        logic [15:0] imm;
        int          pick;
        for (int k = 0; k < count; k++) begin
            rs   = 5'($urandom);
            rt   = 5'($urandom);
            rd   = 5'($urandom);
            sh   = 5'($urandom);
            imm  = 16'($urandom);
            if ($urandom_range(0, 7) == 0) imm = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                w = $urandom;
            end else if (pick < 22) begin
                // malformed encodings of otherwise known instructions
                case ($urandom_range(0, 4))
                    0: w = enc_r(rs, rt, rd, (sh == '0) ? 5'd1 : sh, pick_alu_fn());
                    1: w = enc_r((rs == '0) ? 5'd1 : rs, rt, rd, sh, FN_SLL);
                    2: w = enc_i(OPC_REGIMM, rs, (rt < 5'd2) ? rt + 5'd2 : rt, imm);
                    3: w = enc_i($urandom_range(0, 1) ? OPC_BGTZ : OPC_BLEZ, rs,
                                 (rt == '0) ? 5'd1 : rt, imm);
                    default: w = enc_r(rs, rt, rd, sh, 6'($urandom));
                endcase
            end else if (pick < 40) begin
                w = enc_r(rs, rt, rd, 5'd0, pick_alu_fn());
            end else if (pick < 50) begin
                case ($urandom_range(0, 2))
                    0:       w = enc_r(5'd0, rt, rd, sh, FN_SLL);
                    1:       w = enc_r(rs, rt, rd, sh, FN_SRL);
                    default: w = enc_r(rs, rt, rd, sh, FN_SRA);
                endcase
            end else if (pick < 53) begin
                w = $urandom_range(0, 1) ? enc_r(rs, rt, rd, sh, FN_BREAK) : '0;
            end else if (pick < 61) begin
                w = {OPC_J, 26'($urandom)};
            end else if (pick < 73) begin
                w = enc_i($urandom_range(0, 1) ? OPC_LW : OPC_SW, rs, rt, imm);
            end else if (pick < 89) begin
                case ($urandom_range(0, 2))
                    0: w = enc_i($urandom_range(0, 1) ? OPC_BEQ : OPC_BNE, rs, rt, imm);
                    1: w = enc_i(OPC_REGIMM, rs, $urandom_range(0, 1) ? RT_BGEZ : RT_BLTZ,
                                 imm);
                    default: w = enc_i($urandom_range(0, 1) ? OPC_BGTZ : OPC_BLEZ, rs,
                                       5'd0, imm);
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       w = enc_i(OPC_ADDI, rs, rt, imm);
                    1:       w = enc_i(OPC_ADDIU, rs, rt, imm);
                    default: w = enc_i(OPC_SLTI, rs, rt, imm);
                endcase
            end
            // addresses near both ends exercise target wraparound
            case ($urandom_range(0, 3))
                0:       addr = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
                1:       addr = 32'($urandom_range(0, 255));
                default: addr = $urandom;
            endcase
            issue_instr(swap_now ? reverse_bytes(w) : w, addr, 1'b0, OP_NOP);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        dir_fixed      = 1'b0;
        dir_fixed_op   = OP_NOP;
        swap_now       = 1'b1;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        hold_req       = 1'b0;

        dir_rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b1, OP_NOP});
        dir_rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, OP_UNKNOWN});
        dir_rows.push_back('{enc_r(5'd31, 5'd31, 5'd31, 5'd31, FN_BREAK), 32'h10, 1'b1,
                             OP_BREAK});
        dir_rows.push_back('{enc_r(5'd0, 5'd31, 5'd31, 5'd31, FN_SLL), 32'h14, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd1, 5'd2, 5'd3, 5'd4, FN_SLL), 32'h18, 1'b1, OP_UNKNOWN});
        dir_rows.push_back('{enc_r(5'd31, 5'd5, 5'd6, 5'd31, FN_SRL), 32'h1C, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd31, 5'd7, 5'd8, 5'd1, FN_SRA), 32'h20, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd1, 5'd2, 5'd3, 5'd1, FN_ADD), 32'h24, 1'b1, OP_UNKNOWN});
        dir_rows.push_back('{enc_r(5'd31, 5'd31, 5'd31, 5'd0, FN_SLT), 32'h28, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SLTU), 32'h2C, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_SUB), 32'h30, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd4, 5'd5, 5'd6, 5'd0, FN_SUBU), 32'h34, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd7, 5'd8, 5'd9, 5'd0, FN_ADD), 32'h38, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd10, 5'd11, 5'd12, 5'd0, FN_ADDU), 32'h3C, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd13, 5'd14, 5'd15, 5'd0, FN_AND), 32'h40, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd16, 5'd17, 5'd18, 5'd0, FN_OR), 32'h44, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd19, 5'd20, 5'd21, 5'd0, FN_XOR), 32'h48, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_r(5'd22, 5'd23, 5'd24, 5'd0, FN_NOR), 32'h4C, 1'b0, OP_NOP});
        dir_rows.push_back('{{OPC_J, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_SW, 5'd31, 5'd30, 16'h8000), 32'h50, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_LW, 5'd29, 5'd28, 16'h7FFF), 32'h54, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h7FFF), 32'hFFFF_FFFC, 1'b0,
                             OP_NOP});
        dir_rows.push_back('{enc_i(OPC_BNE, 5'd3, 5'd4, 16'h8000), 32'h0000_0000, 1'b0,
                             OP_NOP});
        dir_rows.push_back('{enc_i(OPC_REGIMM, 5'd5, RT_BGEZ, 16'hFFFF), 32'h58, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_REGIMM, 5'd6, RT_BLTZ, 16'h0001), 32'h5C, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_REGIMM, 5'd7, 5'd2, 16'h0004), 32'h60, 1'b1,
                             OP_UNKNOWN});
        dir_rows.push_back('{enc_i(OPC_BGTZ, 5'd8, 5'd0, 16'h0010), 32'h64, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_BLEZ, 5'd9, 5'd0, 16'hFFF0), 32'h68, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_BLEZ, 5'd9, 5'd3, 16'hFFF0), 32'h6C, 1'b1, OP_UNKNOWN});
        dir_rows.push_back('{enc_i(OPC_ADDI, 5'd10, 5'd11, 16'h8000), 32'h70, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_ADDIU, 5'd12, 5'd13, 16'h7FFF), 32'h74, 1'b0, OP_NOP});
        dir_rows.push_back('{enc_i(OPC_SLTI, 5'd14, 5'd15, 16'hFFFF), 32'h78, 1'b0, OP_NOP});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // byte swapping is on out of reset: feed the table words swapped
        foreach (dir_rows[k])
            issue_instr(swap_now ? reverse_bytes(dir_rows[k].word) : dir_rows[k].word,
                        dir_rows[k].pc, dir_rows[k].fixed, dir_rows[k].fixed_op);

        write_swap(1'b0);
        run_random(350);

        write_swap(1'b1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_random(250);
        // back up the pipeline against a stalled sink
        hold_req = 1'b1;
        run_random(100);

        write_swap(1'b0);
        src_idle_on = 1'b1;
        run_random(300);

        write_swap(1'b1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        run_random(150);

        in_if.valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rid_pkg.sv
rtl/rid_if.sv
rtl/rid_decode.sv
rtl/risc_instruction_decoder_core.sv
tb/sv/tb_top.sv
